// ----- design/apa_pkg.sv -----
// ============================================================================
// Address pool allocator package
// Shared codes, state encoding and memory control struct.
// ============================================================================
package apa_pkg;

    localparam int ADDR_W          = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int HOST_BITS_W     = 4;
    localparam int MIN_HOST_BITS   = 2;

    localparam logic [HOST_BITS_W-1:0] HOST_BITS_RESET = 4'd10;

    // request kinds
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NETWORK_PREFIX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOST_BITS      = 2'd1;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_FREE     = 2'd1,
        STATUS_BAD_RELEASE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LEAF_CHK,
        S_CLIMB,
        S_CLIMB_CHK,
        S_DESC,
        S_ALLOC_SET,
        S_ALLOC_UP,
        S_REL_CHK,
        S_REL_UP,
        S_DONE
    } ctrl_state_t;

    // tree memory port control (addresses travel separately)
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_bit;
    } mem_ctl_t;

endpackage

// ----- design/apa_if.sv -----
// ============================================================================
// Address pool allocator channels
// Request, result and configuration write channels with valid/ready.
// ============================================================================
interface apa_req_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [apa_pkg::ADDR_W-1:0] address;

    modport source (output valid, kind, address, input ready);
    modport sink   (input valid, kind, address, output ready);
endinterface

interface apa_rsp_if #(parameter int COUNT_W = 11);
    logic                       valid;
    logic                       ready;
    apa_pkg::status_t           status;
    logic [apa_pkg::ADDR_W-1:0] assigned_address;
    logic [COUNT_W-1:0]         free_count;

    modport source (output valid, status, assigned_address, free_count, input ready);
    modport sink   (input valid, status, assigned_address, free_count, output ready);
endinterface

interface apa_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [apa_pkg::CFG_IDX_W-1:0] index;
    logic [apa_pkg::ADDR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/address_pool_allocator.sv -----
// ============================================================================
// Address pool allocator
// Hands out host addresses behind a network prefix from a heap-ordered
// full-flag tree held in one synchronous memory.
// ============================================================================
// One request at a time: the next is taken the cycle after the result is
//   registered; a held result stalls the walk in its last state.
// After reset and every host_bits write a sweep rebuilds all 2^(MAX_HOST_BITS+1)-1
//   tree nodes, one node per cycle, with no request taken.
// ============================================================================
module address_pool_allocator #(
    parameter int MAX_HOST_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    apa_req_if.sink     req,
    apa_rsp_if.source   rsp,
    apa_cfg_if.sink     cfg
);

    localparam int NW = MAX_HOST_BITS + 1;

    // configuration registers
    logic [apa_pkg::ADDR_W-1:0]      prefix_reg, prefix_next;
    logic [apa_pkg::HOST_BITS_W-1:0] host_bits_reg, host_bits_next;

    logic                            cfg_open;
    logic                            cfg_write;
    logic                            init_start;

    // tree memory port
    apa_pkg::mem_ctl_t               mem_ctl;
    logic [NW-1:0]                   rd_addr;
    logic [NW-1:0]                   wr_addr;
    logic                            rd_data;

    // Writes are taken while idle or during the init sweep.
    assign cfg.ready  = cfg_open;
    assign cfg_write  = cfg.valid && cfg_open;
    assign init_start = cfg_write && (cfg.index == apa_pkg::REG_HOST_BITS);

    // register decode; indexes past the list are ignored
    always_comb
    begin
        prefix_next    = prefix_reg;
        host_bits_next = host_bits_reg;
        if (cfg_write)
        begin
            unique case (cfg.index)
                apa_pkg::REG_NETWORK_PREFIX: prefix_next    = cfg.data;
                apa_pkg::REG_HOST_BITS:      host_bits_next = cfg.data[apa_pkg::HOST_BITS_W-1:0];
                default:                     prefix_next    = prefix_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= '0;
            host_bits_reg <= apa_pkg::HOST_BITS_RESET;
        end
        else
        begin
            prefix_reg    <= prefix_next;
            host_bits_reg <= host_bits_next;
        end
    end

    // Sequencer: init sweep, lowest-free search, path update, result register.
    apa_ctrl #(
        .MAX_HOST_BITS (MAX_HOST_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .init_start     (init_start),
        .network_prefix (prefix_reg),
        .host_bits      (host_bits_reg),
        .cfg_open       (cfg_open),
        .req            (req),
        .rsp            (rsp),
        .mem_ctl        (mem_ctl),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr),
        .rd_data        (rd_data)
    );

    // Node 1 is the root; leaves sit at 2^MAX_HOST_BITS + host. A leaf holds
    // its busy bit, an inner node the AND of its children.
    apa_tree_mem #(
        .AW (NW)
    ) u_tree_mem (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .rd_data (rd_data)
    );

endmodule

// ----- design/apa_tree_mem.sv -----
// ============================================================================
// Tree memory
// One bit per heap node: full flag for inner nodes, busy flag for leaves.
// One write port, one read port, registered read data.
// ============================================================================
module apa_tree_mem #(
    parameter int AW = 11
) (
    input  logic                      clk,
    input  apa_pkg::mem_ctl_t         mem_ctl,
    input  logic [AW-1:0]             rd_addr,
    input  logic [AW-1:0]             wr_addr,
    output logic                      rd_data
);

    localparam int DEPTH = 2 ** AW;

    logic mem_array [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem_array[wr_addr] <= mem_ctl.wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/apa_ctrl.sv -----
// ============================================================================
// Allocator sequencer
// Init sweep, find-first-free walk, tree update, free count, result register.
// ============================================================================
module apa_ctrl #(
    parameter int MAX_HOST_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              init_start,
    input  logic [apa_pkg::ADDR_W-1:0]        network_prefix,
    input  logic [apa_pkg::HOST_BITS_W-1:0]   host_bits,
    output logic                              cfg_open,
    apa_req_if.sink                           req,
    apa_rsp_if.source                         rsp,
    output apa_pkg::mem_ctl_t                 mem_ctl,
    output logic [MAX_HOST_BITS:0]            rd_addr,
    output logic [MAX_HOST_BITS:0]            wr_addr,
    input  logic                              rd_data
);

    localparam int NW = MAX_HOST_BITS + 1;          // heap node index
    localparam int LW = MAX_HOST_BITS;              // host index
    localparam int CW = MAX_HOST_BITS + 1;          // free count
    localparam int EW = $clog2(MAX_HOST_BITS + 1);  // effective host bits / level

    apa_pkg::ctrl_state_t state_reg, state_next;

    logic [NW-1:0]              node_reg, node_next;
    logic                       cv_reg, cv_next;
    logic [LW-1:0]              host_reg, host_next;
    logic [LW-1:0]              found_reg, found_next;
    logic                       kind_reg, kind_next;
    apa_pkg::status_t           res_status_reg, res_status_next;
    logic [CW-1:0]              free_total_reg, free_total_next;
    logic [EW-1:0]              lvl_reg, lvl_next;
    logic [LW-1:0]              off_reg, off_next;

    logic                       out_valid_reg, out_valid_next;
    apa_pkg::status_t           out_status_reg, out_status_next;
    logic [apa_pkg::ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [CW-1:0]              out_count_reg, out_count_next;

    logic [EW-1:0]              eff;
    logic [NW-1:0]              size;
    logic [LW-1:0]              mask_h;
    logic [LW-1:0]              req_host;
    logic [NW-1:0]              leaf_node;
    logic [NW-1:0]              sib_node;
    logic [NW-1:0]              child_node;
    logic [NW-1:0]              parent_node;
    logic [NW-1:0]              init_node;
    logic [LW-1:0]              init_lo;
    logic [NW-1:0]              init_lo_ext;
    logic [LW-1:0]              level_top;
    logic                       init_full;
    logic                       slot_free;
    logic                       ok_alloc;
    logic                       ok_release;

    // effective pool geometry
    always_comb
    begin
        if (int'(host_bits) < apa_pkg::MIN_HOST_BITS)
            eff = EW'(apa_pkg::MIN_HOST_BITS);
        else if (int'(host_bits) > MAX_HOST_BITS)
            eff = EW'(MAX_HOST_BITS);
        else
            eff = EW'(host_bits);
        size   = NW'(1) << eff;
        mask_h = LW'(size - NW'(1));
    end

    assign req_host    = req.address[LW-1:0] & mask_h;
    assign leaf_node   = {1'b1, host_reg};
    assign sib_node    = node_reg | NW'(1);
    assign child_node  = {node_reg[NW-2:0], rd_data};
    assign parent_node = node_reg >> 1;

    // init sweep: node at (level, offset) covers an aligned run of leaves
    assign init_node   = (NW'(1) << lvl_reg) | NW'(off_reg);
    assign init_lo     = LW'(off_reg << (EW'(MAX_HOST_BITS) - lvl_reg));
    assign init_lo_ext = {1'b0, init_lo};
    assign level_top   = LW'((NW'(1) << lvl_reg) - NW'(1));

    // full when the run lies beyond the pool, is a reserved leaf, or is the
    // pair of reserved hosts at the top of the pool
    assign init_full =
        (init_lo_ext >= size) ||
        ((lvl_reg == EW'(MAX_HOST_BITS)) &&
         ((init_lo == '0) || (init_lo_ext == NW'(size - NW'(2))) ||
          (init_lo_ext == NW'(size - NW'(1))))) ||
        ((lvl_reg == EW'(MAX_HOST_BITS - 1)) && (init_lo_ext == NW'(size - NW'(2))));

    assign slot_free  = !out_valid_reg || rsp.ready;
    assign ok_alloc   = (res_status_reg == apa_pkg::STATUS_OK) && (kind_reg == apa_pkg::KIND_ALLOC);
    assign ok_release = (res_status_reg == apa_pkg::STATUS_OK) && (kind_reg == apa_pkg::KIND_RELEASE);

    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        cv_next         = cv_reg;
        host_next       = host_reg;
        found_next      = found_reg;
        kind_next       = kind_reg;
        res_status_next = res_status_reg;
        free_total_next = free_total_reg;
        lvl_next        = lvl_reg;
        off_next        = off_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_count_next  = out_count_reg;
        mem_ctl         = '0;
        rd_addr         = '0;
        wr_addr         = '0;
        req.ready       = 1'b0;
        cfg_open        = 1'b0;

        unique case (state_reg)
            apa_pkg::S_INIT:
            begin
                cfg_open       = 1'b1;
                mem_ctl.wr_en  = 1'b1;
                mem_ctl.wr_bit = init_full;
                wr_addr        = init_node;
                if (off_reg == level_top)
                begin
                    off_next = '0;
                    lvl_next = lvl_reg + EW'(1);
                    if (lvl_reg == EW'(MAX_HOST_BITS))
                    begin
                        free_total_next = CW'(size - NW'(3));
                        state_next      = apa_pkg::S_IDLE;
                    end
                end
                else
                begin
                    off_next = off_reg + LW'(1);
                end
            end

            apa_pkg::S_IDLE:
            begin
                // a host_bits write in the same cycle wins; the request waits
                cfg_open  = 1'b1;
                req.ready = !init_start;
                if (req.valid && !init_start)
                begin
                    kind_next = req.kind;
                    host_next = req_host;
                    if (req.kind == apa_pkg::KIND_ALLOC)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = {1'b1, req_host};
                        state_next    = apa_pkg::S_LEAF_CHK;
                    end
                    else if ((req_host == '0) || (req_host >= mask_h - LW'(1)))
                    begin
                        res_status_next = apa_pkg::STATUS_BAD_RELEASE;
                        state_next      = apa_pkg::S_DONE;
                    end
                    else
                    begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = {1'b1, req_host};
                        state_next    = apa_pkg::S_REL_CHK;
                    end
                end
            end

            apa_pkg::S_LEAF_CHK:
            begin
                node_next = leaf_node;
                if (!rd_data)
                    state_next = apa_pkg::S_ALLOC_SET;
                else
                    state_next = apa_pkg::S_CLIMB;
            end

            apa_pkg::S_CLIMB:
            begin
                if (node_reg == NW'(1))
                begin
                    res_status_next = apa_pkg::STATUS_NO_FREE;
                    state_next      = apa_pkg::S_DONE;
                end
                else if (!node_reg[0])
                begin
                    // left child: look at the right sibling
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = sib_node;
                    state_next    = apa_pkg::S_CLIMB_CHK;
                end
                else
                begin
                    node_next = parent_node;
                end
            end

            apa_pkg::S_CLIMB_CHK:
            begin
                if (!rd_data)
                begin
                    node_next = sib_node;
                    if (sib_node[NW-1])
                    begin
                        state_next = apa_pkg::S_ALLOC_SET;
                    end
                    else
                    begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = {sib_node[NW-2:0], 1'b0};
                        state_next    = apa_pkg::S_DESC;
                    end
                end
                else
                begin
                    node_next  = parent_node;
                    state_next = apa_pkg::S_CLIMB;
                end
            end

            apa_pkg::S_DESC:
            begin
                // rd_data is the left child's full flag
                node_next = child_node;
                if (child_node[NW-1])
                begin
                    state_next = apa_pkg::S_ALLOC_SET;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = {child_node[NW-2:0], 1'b0};
                end
            end

            apa_pkg::S_ALLOC_SET:
            begin
                mem_ctl.wr_en  = 1'b1;
                mem_ctl.wr_bit = 1'b1;
                wr_addr        = node_reg;
                mem_ctl.rd_en  = 1'b1;
                rd_addr        = node_reg ^ NW'(1);
                found_next     = node_reg[LW-1:0];
                cv_next        = 1'b1;
                state_next     = apa_pkg::S_ALLOC_UP;
            end

            apa_pkg::S_ALLOC_UP:
            begin
                // parent full = this child full and its sibling full
                mem_ctl.wr_en  = 1'b1;
                mem_ctl.wr_bit = cv_reg & rd_data;
                wr_addr        = parent_node;
                cv_next        = cv_reg & rd_data;
                node_next      = parent_node;
                if (parent_node == NW'(1))
                begin
                    res_status_next = apa_pkg::STATUS_OK;
                    state_next      = apa_pkg::S_DONE;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = parent_node ^ NW'(1);
                end
            end

            apa_pkg::S_REL_CHK:
            begin
                if (!rd_data)
                begin
                    res_status_next = apa_pkg::STATUS_BAD_RELEASE;
                    state_next      = apa_pkg::S_DONE;
                end
                else
                begin
                    mem_ctl.wr_en  = 1'b1;
                    mem_ctl.wr_bit = 1'b0;
                    wr_addr        = leaf_node;
                    node_next      = leaf_node >> 1;
                    state_next     = apa_pkg::S_REL_UP;
                end
            end

            apa_pkg::S_REL_UP:
            begin
                // a freed leaf clears every ancestor
                mem_ctl.wr_en  = 1'b1;
                mem_ctl.wr_bit = 1'b0;
                wr_addr        = node_reg;
                node_next      = parent_node;
                if (node_reg == NW'(1))
                begin
                    res_status_next = apa_pkg::STATUS_OK;
                    state_next      = apa_pkg::S_DONE;
                end
            end

            apa_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    if (ok_alloc)
                        free_total_next = free_total_reg - CW'(1);
                    else if (ok_release)
                        free_total_next = free_total_reg + CW'(1);
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = ok_alloc ?
                        (network_prefix & ~apa_pkg::ADDR_W'(mask_h)) +
                        apa_pkg::ADDR_W'(found_reg) : '0;
                    out_count_next  = ok_alloc ? free_total_reg - CW'(1) :
                                      ok_release ? free_total_reg + CW'(1) :
                                      free_total_reg;
                    state_next      = apa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = apa_pkg::S_INIT;
            end
        endcase

        // host_bits write restarts the sweep
        if (init_start)
        begin
            state_next = apa_pkg::S_INIT;
            lvl_next   = '0;
            off_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apa_pkg::S_INIT;
            lvl_reg       <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            off_reg       <= off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        cv_reg         <= cv_next;
        host_reg       <= host_next;
        found_reg      <= found_next;
        kind_reg       <= kind_next;
        res_status_reg <= res_status_next;
        free_total_reg <= free_total_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.assigned_address = out_addr_reg;
    assign rsp.free_count       = out_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.rd_en && mem_ctl.wr_en) |-> (rd_addr != wr_addr))
        else $error("tree memory read and write hit the same node");

    a_set_on_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apa_pkg::S_ALLOC_SET) |-> node_reg[NW-1])
        else $error("allocation marks a non-leaf node");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apa_pkg::S_IDLE) |-> (free_total_reg <= CW'(size - NW'(3))))
        else $error("free count above pool capacity");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apa_pkg::S_DONE && out_valid_reg && !rsp.ready && !init_start)
        |=> (state_reg == apa_pkg::S_DONE))
        else $error("result dropped while output register busy");

endmodule

// ----- test/address_pool_allocator_tb.sv -----
// ============================================================================
// Address pool allocator testbench
// Self-checking bench: a queue-fed request driver, a response monitor and an
// in-bench model of the host pool. Directed corner requests come first, then
// randomized allocate/release traffic over several pool settings and
// handshake pressure profiles.
// ============================================================================
module address_pool_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          POOL_BITS     = 10;
    localparam int          POOL_DEPTH    = 1 << POOL_BITS;
    localparam int          COUNT_W       = 11;
    // leave margin for the worst walk before touching registers
    localparam int          SETTLE_CYCLES = 80;
    localparam int          BATCH_LEN     = 16;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          REPORT_MAX    = 10;

    typedef struct {
        logic                       kind;
        logic [apa_pkg::ADDR_W-1:0] address;
    } pool_request_t;

    typedef struct {
        apa_pkg::status_t           status;
        logic [apa_pkg::ADDR_W-1:0] assigned_address;
        logic [COUNT_W-1:0]         free_count;
    } pool_result_t;

    logic clk = 1'b0;
    logic rst_n;

    apa_req_if                     req_ch ();
    apa_rsp_if #(.COUNT_W(COUNT_W)) rsp_ch ();
    apa_cfg_if                     cfg_ch ();

    address_pool_allocator #(
        .MAX_HOST_BITS(POOL_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Pool model: one used bit per host, the free total and both registers.
    // A grant is simply the lowest unused host from the masked request up to
    // the top of the pool; the tree in the block must agree with that.
    // ------------------------------------------------------------------------
    bit                         pool_used [0:POOL_DEPTH-1];
    logic [apa_pkg::ADDR_W-1:0] pool_prefix;
    logic [3:0]                 pool_host_bits;
    int unsigned                pool_free;

    pool_request_t      pending_q [$];
    pool_result_t       expected_q [$];
    pool_request_t      drv_item;
    pool_result_t       mon_exp;

    int unsigned        n_issued;
    int unsigned        n_checked;
    int unsigned        mismatch_count;
    int unsigned        cycle_count;
    int unsigned        n_granted;
    int unsigned        n_refused;
    int unsigned        n_released;
    int unsigned        n_bad_release;
    int unsigned        n_settings;
    int                 send_idle_pct;
    int                 rcv_stall_pct;

    // host_bits saturates to the range the block supports
    function automatic int unsigned active_host_bits();
        int unsigned h;
        h = pool_host_bits;
        if (h < apa_pkg::MIN_HOST_BITS)
            h = apa_pkg::MIN_HOST_BITS;
        if (h > POOL_BITS)
            h = POOL_BITS;
        return h;
    endfunction

    function automatic logic [apa_pkg::ADDR_W-1:0] host_mask();
        return (32'd1 << active_host_bits()) - 32'd1;
    endfunction

    // fresh pool: host 0 and the top two hosts are reserved
    function automatic void init_pool();
        int unsigned size;
        size = 1 << active_host_bits();
        foreach (pool_used[i])
            pool_used[i] = 1'b0;
        pool_used[0]      = 1'b1;
        pool_used[size-2] = 1'b1;
        pool_used[size-1] = 1'b1;
        pool_free = size - 3;
    endfunction

    function automatic pool_result_t apply_request(logic kind,
                                                   logic [apa_pkg::ADDR_W-1:0] address);
        pool_result_t               r;
        logic [apa_pkg::ADDR_W-1:0] mask;
        logic [apa_pkg::ADDR_W-1:0] host;
        int unsigned                grant;
        mask               = host_mask();
        host               = address & mask;
        r.status           = apa_pkg::STATUS_OK;
        r.assigned_address = '0;
        if (kind == apa_pkg::KIND_ALLOC)
        begin
            grant = host;
            while (grant <= mask && pool_used[grant])
                grant++;
            if (grant <= mask)
            begin
                pool_used[grant]   = 1'b1;
                pool_free--;
                r.assigned_address = (pool_prefix & ~mask) + grant;
                n_granted++;
            end
            else
            begin
                r.status = apa_pkg::STATUS_NO_FREE;
                n_refused++;
            end
        end
        else
        begin
            if (host == 0 || host >= mask - 1 || !pool_used[host])
            begin
                r.status = apa_pkg::STATUS_BAD_RELEASE;
                n_bad_release++;
            end
            else
            begin
                pool_used[host] = 1'b0;
                pool_free++;
                n_released++;
            end
        end
        r.free_count = pool_free[COUNT_W-1:0];
        return r;
    endfunction

    // random used, non-reserved host, or -1 when the pool holds none
    function automatic int pick_used_host(logic [apa_pkg::ADDR_W-1:0] mask);
        int unsigned span;
        int unsigned start;
        int unsigned cand;
        span  = mask - 2;
        start = $urandom_range(0, span - 1);
        for (int unsigned k = 0; k < span; k++)
        begin
            cand = 1 + (start + k) % span;
            if (pool_used[cand])
                return cand;
        end
        return -1;
    endfunction

    task automatic note_mismatch(input string what, input logic [apa_pkg::ADDR_W-1:0] exp_v,
                                 input logic [apa_pkg::ADDR_W-1:0] act_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] mismatch %0d, %s: expected %0h, got %0h",
                     $realtime, mismatch_count, what, exp_v, act_v);
    endtask

    // ------------------------------------------------------------------------
    // Request driver. The model is advanced at the acceptance edge, using
    // what was on the bus; the next request goes out on the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_q.push_back(apply_request(req_ch.kind, req_ch.address));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drv_item        = pending_q.pop_front();
                    req_ch.valid   <= 1'b1;
                    req_ch.kind    <= drv_item.kind;
                    req_ch.address <= drv_item.address;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor with random back-pressure.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    note_mismatch("result with nothing outstanding", '0,
                                  rsp_ch.assigned_address);
                end
                else
                begin
                    mon_exp = expected_q.pop_front();
                    if (rsp_ch.status !== mon_exp.status)
                        note_mismatch("status", mon_exp.status, rsp_ch.status);
                    if (rsp_ch.assigned_address !== mon_exp.assigned_address)
                        note_mismatch("assigned_address", mon_exp.assigned_address,
                                      rsp_ch.assigned_address);
                    if (rsp_ch.free_count !== mon_exp.free_count)
                        note_mismatch("free_count", mon_exp.free_count, rsp_ch.free_count);
                    n_checked++;
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d of %0d requests answered",
                     cycle_count, n_checked, n_issued);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_request(input logic kind, input logic [apa_pkg::ADDR_W-1:0] address);
        pool_request_t it;
        it.kind    = kind;
        it.address = address;
        pending_q.push_back(it);
        n_issued++;
    endtask

    // all results in, then let any walk still in the block run out
    task automatic settle();
        wait (n_checked == n_issued);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register writes wait until the block takes them, which it does while idle or
    // during the init sweep; the model follows at the accepting edge
    task automatic write_reg(input logic [apa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [apa_pkg::ADDR_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == apa_pkg::REG_NETWORK_PREFIX)
        begin
            pool_prefix = value;
        end
        else
        begin
            pool_host_bits = value[3:0];
            init_pool();
            n_settings++;
        end
    endtask

    // Mostly well-formed traffic: allocations biased to the bottom and top of
    // the pool, releases mostly of hosts the model knows to be in use. The
    // rest are releases of random hosts, reserved ones included. Upper address
    // bits are random throughout and must be ignored.
    task automatic queue_random_request();
        logic [apa_pkg::ADDR_W-1:0] mask;
        logic [apa_pkg::ADDR_W-1:0] host;
        logic [apa_pkg::ADDR_W-1:0] upper;
        int                         pick;
        mask  = host_mask();
        upper = $urandom();
        if ($urandom_range(0, 99) < 55)
        begin
            case ($urandom_range(0, 9))
                0, 1:    host = $urandom_range(0, 3);
                2, 3:    host = mask - $urandom_range(0, 3);
                default: host = $urandom_range(0, mask);
            endcase
            queue_request(apa_pkg::KIND_ALLOC, (upper & ~mask) | (host & mask));
        end
        else
        begin
            pick = pick_used_host(mask);
            if (pick >= 0 && $urandom_range(0, 9) < 7)
                host = pick;
            else
                host = $urandom_range(0, mask);
            queue_request(apa_pkg::KIND_RELEASE, (upper & ~mask) | (host & mask));
        end
    endtask

    // short batches so release picks see a current view of the pool
    task automatic run_random(input int unsigned n_items);
        int unsigned left;
        int unsigned batch;
        left = n_items;
        while (left > 0)
        begin
            batch = (left < BATCH_LEN) ? left : BATCH_LEN;
            repeat (batch) queue_random_request();
            left -= batch;
            wait (n_checked == n_issued);
        end
    endtask

    task automatic run_phase(input logic [3:0] bits, input bit new_bits,
                             input logic [apa_pkg::ADDR_W-1:0] prefix,
                             input int idle, input int stall, input int unsigned n_items);
        settle();
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        write_reg(apa_pkg::REG_NETWORK_PREFIX, prefix);
        if (new_bits)
            write_reg(apa_pkg::REG_HOST_BITS, {28'd0, bits});
        send_idle_pct = idle;
        rcv_stall_pct = stall;
        run_random(n_items);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.kind    = apa_pkg::KIND_ALLOC;
        req_ch.address = '0;
        rsp_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = apa_pkg::REG_NETWORK_PREFIX;
        cfg_ch.data    = '0;
        send_idle_pct  = 0;
        rcv_stall_pct  = 0;
        n_issued       = 0;
        n_checked      = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        n_granted      = 0;
        n_refused      = 0;
        n_released     = 0;
        n_bad_release  = 0;
        n_settings     = 1;
        pool_prefix    = '0;
        pool_host_bits = apa_pkg::HOST_BITS_RESET;
        init_pool();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // smallest pool: only host 1 can ever be handed out
        write_reg(apa_pkg::REG_NETWORK_PREFIX, 32'hFFFF_FFFF);
        write_reg(apa_pkg::REG_HOST_BITS, 32'd2);
        queue_request(apa_pkg::KIND_ALLOC,   32'h0000_0000);   // gets host 1
        queue_request(apa_pkg::KIND_ALLOC,   32'h0000_0000);   // pool exhausted
        queue_request(apa_pkg::KIND_ALLOC,   32'hFFFF_FFFF);   // reserved top, nothing above
        queue_request(apa_pkg::KIND_RELEASE, 32'h0000_0001);
        queue_request(apa_pkg::KIND_RELEASE, 32'h0000_0001);   // already free
        queue_request(apa_pkg::KIND_RELEASE, 32'h0000_0000);   // reserved bottom
        queue_request(apa_pkg::KIND_RELEASE, 32'hFFFF_FFFE);   // reserved top pair
        queue_request(apa_pkg::KIND_RELEASE, 32'h0000_0003);
        queue_request(apa_pkg::KIND_ALLOC,   32'hFFFF_FFFE);   // starts on a reserved host
        queue_request(apa_pkg::KIND_ALLOC,   32'hFFFF_FFFD);   // host 1 behind all-ones prefix
        settle();

        // out-of-range host_bits saturates to the full pool
        write_reg(apa_pkg::REG_NETWORK_PREFIX, 32'h0000_0000);
        write_reg(apa_pkg::REG_HOST_BITS, 32'd15);
        queue_request(apa_pkg::KIND_ALLOC,   32'h0000_0000);
        queue_request(apa_pkg::KIND_ALLOC,   32'h0000_03FD);   // highest grantable host
        queue_request(apa_pkg::KIND_ALLOC,   32'h0000_03FE);   // refused, only reserved above
        queue_request(apa_pkg::KIND_ALLOC,   32'hFFFF_FFFF);
        queue_request(apa_pkg::KIND_RELEASE, 32'h0000_03FF);
        queue_request(apa_pkg::KIND_RELEASE, 32'hFFFF_FC01);   // high bits ignored
        queue_request(apa_pkg::KIND_ALLOC,   32'h0000_0200);
        queue_request(apa_pkg::KIND_ALLOC,   32'h0000_01FF);
        queue_request(apa_pkg::KIND_RELEASE, 32'h0000_03FD);
        queue_request(apa_pkg::KIND_ALLOC,   32'h0000_03FC);
        queue_request(apa_pkg::KIND_ALLOC,   32'h0000_03FC);   // steps over the one just taken
        settle();

        // below-range host_bits clamps to the smallest pool
        write_reg(apa_pkg::REG_NETWORK_PREFIX, 32'h1234_5678);
        write_reg(apa_pkg::REG_HOST_BITS, 32'd0);
        queue_request(apa_pkg::KIND_ALLOC,   32'h8000_0002);   // wraps to nothing free above
        queue_request(apa_pkg::KIND_ALLOC,   32'h8000_0001);
        queue_request(apa_pkg::KIND_RELEASE, 32'h7FFF_FFFD);

        // random traffic over several pool shapes and pressure profiles
        run_phase(4'd4,  1'b1, $urandom(),   0,  0, 200);
        run_phase(4'd10, 1'b1, 32'hFFFF_FFFF, 67,  0, 200);
        run_phase(4'd3,  1'b1, 32'h0000_0000, 0, 67, 200);
        run_phase(4'd15, 1'b1, $urandom(),   9,  9, 200);
        run_phase(4'd1,  1'b1, $urandom(),   0,  0, 60);
        // prefix alone changes; the pool contents carry over
        run_phase(4'd1,  1'b0, $urandom(),  67, 67, 60);
        run_phase(4'd6,  1'b1, $urandom(),   0,  0, 100);

        settle();
        if (expected_q.size() != 0)
            note_mismatch("results never delivered", expected_q.size(), '0);

        $display("Checked %0d requests over %0d pool settings: %0d granted, %0d refused,",
                 n_checked, n_settings, n_granted, n_refused);
        $display("  %0d released, %0d release attempts rejected, %0d mismatches",
                 n_released, n_bad_release, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
